### design/ldass_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldass_pkg
// Shared types, constants and the arctangent table for landmark association.
// ----------------------------------------------------------------------------
package ldass_pkg;

  localparam int CORDIC_STEPS = 14;
  localparam int XW           = 24;    // CORDIC vector width, Q12.12
  localparam int ZW           = 18;    // residual angle width
  localparam int CW           = 24;    // coordinate width
  localparam int D2W          = 51;    // squared distance width
  localparam int TW           = 46;    // squared radius width
  localparam logic [15:0] CORDIC_GAIN = 16'd39797;
  localparam logic [TW-1:0] THR2_RESET = 46'd1677721600;  // 40960^2

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ROT,
    S_SCAN
  } state_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic [13:0] atan_ba(input int i);
    logic [13:0] r;
    unique case (i)
      0:       r = 14'd8192;
      1:       r = 14'd4836;
      2:       r = 14'd2555;
      3:       r = 14'd1297;
      4:       r = 14'd651;
      5:       r = 14'd326;
      6:       r = 14'd163;
      7:       r = 14'd81;
      8:       r = 14'd41;
      9:       r = 14'd20;
      10:      r = 14'd10;
      11:      r = 14'd5;
      12:      r = 14'd3;
      13:      r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

### design/ldass_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldass_cordic_cell
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module ldass_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  ldass_pkg::cord_t in_vec,
  output logic            out_valid,
  output ldass_pkg::cord_t out_vec
);
  import ldass_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] at;
  cord_t                nv;

  assign xs = in_vec.x >>> STEP;
  assign ys = in_vec.y >>> STEP;
  assign at = signed'(ZW'(atan_ba(STEP)));

  always_comb begin
    if (!in_vec.z[ZW-1]) begin
      nv.x = in_vec.x - ys;
      nv.y = in_vec.y + xs;
      nv.z = in_vec.z - at;
    end else begin
      nv.x = in_vec.x + ys;
      nv.y = in_vec.y - xs;
      nv.z = in_vec.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_vec <= nv;
  end

endmodule

### design/ldass_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldass_cordic
// Row of CORDIC cells; the vector moves one cell per clock.
// ----------------------------------------------------------------------------
module ldass_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ldass_pkg::cord_t in_vec,
  output logic             out_valid,
  output ldass_pkg::cord_t out_vec
);
  import ldass_pkg::*;

  cord_t vec [0:CORDIC_STEPS];
  logic  vld [0:CORDIC_STEPS];

  assign vec[0] = in_vec;
  assign vld[0] = in_valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    ldass_cordic_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_vec    (vec[i]),
      .out_valid (vld[i+1]),
      .out_vec   (vec[i+1])
    );
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_vec   = vec[CORDIC_STEPS];

endmodule

### design/ldass_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldass_map
// Landmark store and nearest-entry scan, one entry per clock, 4-stage pipe.
// ----------------------------------------------------------------------------
module ldass_map #(
  parameter int MAP_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic signed [ldass_pkg::CW-1:0] point_x,
  input  logic signed [ldass_pkg::CW-1:0] point_y,
  input  logic [$clog2(MAP_DEPTH):0]     count,
  input  logic                           wr_en,
  input  logic [$clog2(MAP_DEPTH)-1:0]   wr_addr,
  output logic                           scan_done,
  output logic                           have,
  output logic [$clog2(MAP_DEPTH)-1:0]   best_idx,
  output logic [ldass_pkg::D2W-1:0]      best_d2
);
  import ldass_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  logic signed [CW-1:0] mem_x [MAP_DEPTH];
  logic signed [CW-1:0] mem_y [MAP_DEPTH];

  logic          scanning;
  logic [AW:0]   j;
  logic          empty_done;

  logic                 v1, l1;
  logic [AW-1:0]        i1;
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 v2, l2;
  logic [AW-1:0]        i2;
  logic signed [CW:0]   ex, ey;
  logic                 v3, l3;
  logic [AW-1:0]        i3;
  logic signed [2*CW+1:0] sqx, sqy;
  logic [D2W-1:0]       d2;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= point_x;
      mem_y[wr_addr] <= point_y;
    end
    if (scanning) begin
      rd_x <= mem_x[j[AW-1:0]];
      rd_y <= mem_y[j[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning   <= 1'b0;
      empty_done <= 1'b0;
      j          <= '0;
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      have       <= 1'b0;
      scan_done  <= 1'b0;
    end else begin
      empty_done <= go && (count == '0);
      if (go) begin
        scanning <= (count != '0);
        j        <= '0;
        have     <= 1'b0;
      end else if (scanning) begin
        j <= j + 1'b1;
        if (j + 1'b1 == count) begin
          scanning <= 1'b0;
        end
      end
      v1 <= scanning;
      v2 <= v1;
      v3 <= v2;
      if (v3 && (!have || d2 < best_d2)) begin
        have <= 1'b1;
      end
      scan_done <= (v3 && l3) || empty_done;
    end
  end

  assign d2 = D2W'($unsigned(sqx)) + D2W'($unsigned(sqy));

  always_ff @(posedge clk) begin
    i1  <= j[AW-1:0];
    l1  <= (j + 1'b1 == count);
    ex  <= (CW+1)'(point_x) - (CW+1)'(rd_x);
    ey  <= (CW+1)'(point_y) - (CW+1)'(rd_y);
    i2  <= i1;
    l2  <= l1;
    sqx <= ex * ex;
    sqy <= ey * ey;
    i3  <= i2;
    l3  <= l2;
    if (v3 && (!have || d2 < best_d2)) begin
      best_d2  <= d2;
      best_idx <= i3;
    end
  end

endmodule

### design/landmark_data_association_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_data_association_top
// Nearest-neighbour landmark association for range/bearing readings.
// ----------------------------------------------------------------------------
// Usage:
//   A reading (pose plus range/bearing) is transferred at a rising edge with
//   start high and busy low. busy then stays high until the result is out.
//   The reading is projected to a world point through a 14-cell CORDIC row,
//   then the stored map is scanned for the closest landmark by squared
//   distance, one entry per clock. A match inside the match radius returns its
//   index; otherwise the point is appended, or map_full is raised when no
//   entry is free.
//   After the transfer a reading passes the prep state, the 14 CORDIC
//   cells, one scan read per stored landmark and the 4 map pipe stages
//   (an empty map skips both) and the result register before done rises.
//   busy falls with done, so a new reading waits for the previous result.
//   The result is held on the ports for one cycle with done high; the
//   receiver cannot stall, so it must take every transfer.
//   Configuration: cfg_data (match radius, unsigned Q11.12) is written
//   with cfg_valid/cfg_ready, by the user only while the block is idle
//   (not enforced by the block). The squared radius is stored at write time.
//   Reset: map emptied (count cleared), radius back to 10 m, block idle.
// ----------------------------------------------------------------------------
module landmark_data_association_top #(
  parameter int MAP_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] robot_x,
  input  logic signed [23:0] robot_y,
  input  logic [15:0]        robot_heading,
  input  logic [15:0]        meas_range,
  input  logic [15:0]        meas_bearing,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [22:0]        cfg_data,
  output logic               done,
  output logic [7:0]         landmark_index,
  output logic               created_new,
  output logic               map_full,
  output logic signed [23:0] point_x,
  output logic signed [23:0] point_y
);
  import ldass_pkg::*;

  localparam int AW = $clog2(MAP_DEPTH);

  state_t state, state_next;

  // registered reading
  logic signed [CW-1:0] rx, ry;
  logic [15:0]          ang;
  logic [15:0]          rng;
  logic                 flip;

  logic [TW-1:0] thr2;
  logic [AW:0]   count;

  // CORDIC row
  logic         cin_valid;
  cord_t        cin_vec;
  logic         cout_valid;
  cord_t        cout_vec;
  logic [35:0]  gain_prod;
  logic [15:0]  fang;

  // post-rotation point
  logic signed [CW-1:0] px, py;
  logic signed [XW:0]   nx, ny;
  logic signed [CW+1:0] sx, sy;
  logic signed [CW-1:0] sat_x, sat_y;

  // scan
  logic                 go;
  logic                 scan_done;
  logic                 have;
  logic [AW-1:0]        best_idx;
  logic [D2W-1:0]       best_d2;
  logic                 match;
  logic                 room;
  logic                 wr_en;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // ---- state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cin_valid  = 1'b0;
    go         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PREP;
      end
      S_PREP: begin
        cin_valid  = 1'b1;
        state_next = S_ROT;
      end
      S_ROT: begin
        if (cout_valid) begin
          go         = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- reading capture; fold angle into [-90, 90) deg
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      rx  <= robot_x;
      ry  <= robot_y;
      ang <= robot_heading + meas_bearing;
      rng <= meas_range;
    end
  end

  assign flip      = ang[15] ^ ang[14];
  assign fang      = flip ? (ang ^ 16'h8000) : ang;
  assign gain_prod = {16'd0, rng, 4'd0} * {20'd0, CORDIC_GAIN};

  always_comb begin
    cin_vec.x = signed'(XW'((gain_prod + 36'd32768) >> 16));
    cin_vec.y = '0;
    cin_vec.z = ZW'(signed'(fang));
  end

  ldass_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cin_valid),
    .in_vec    (cin_vec),
    .out_valid (cout_valid),
    .out_vec   (cout_vec)
  );

  // ---- undo fold, add pose, saturate
  assign nx = flip ? -(XW+1)'(cout_vec.x) : (XW+1)'(cout_vec.x);
  assign ny = flip ? -(XW+1)'(cout_vec.y) : (XW+1)'(cout_vec.y);
  assign sx = (CW+2)'(rx) + (CW+2)'(nx);
  assign sy = (CW+2)'(ry) + (CW+2)'(ny);

  always_comb begin
    if (sx > 26'sd8388607)       sat_x = 24'sh7FFFFF;
    else if (sx < -26'sd8388608) sat_x = 24'sh800000;
    else                         sat_x = sx[CW-1:0];
    if (sy > 26'sd8388607)       sat_y = 24'sh7FFFFF;
    else if (sy < -26'sd8388608) sat_y = 24'sh800000;
    else                         sat_y = sy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (go) begin
      px <= sat_x;
      py <= sat_y;
    end
  end

  ldass_map #(.MAP_DEPTH(MAP_DEPTH)) u_map (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .point_x   (px),
    .point_y   (py),
    .count     (count),
    .wr_en     (wr_en),
    .wr_addr   (count[AW-1:0]),
    .scan_done (scan_done),
    .have      (have),
    .best_idx  (best_idx),
    .best_d2   (best_d2)
  );

  // ---- decision, taken as the last distance lands
  assign match = have && (best_d2 < D2W'(thr2));
  assign room  = (count < (AW+1)'(MAP_DEPTH));
  assign wr_en = (state == S_SCAN) && scan_done && !match && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      thr2  <= THR2_RESET;
      done  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr2 <= TW'(cfg_data) * TW'(cfg_data);
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end
      done <= (state == S_SCAN) && scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && scan_done) begin
      point_x <= px;
      point_y <= py;
      if (match) begin
        landmark_index <= 8'(best_idx);
        created_new    <= 1'b0;
        map_full       <= 1'b0;
      end else if (room) begin
        landmark_index <= 8'(count[AW-1:0]);
        created_new    <= 1'b1;
        map_full       <= 1'b0;
      end else begin
        landmark_index <= '0;
        created_new    <= 1'b0;
        map_full       <= 1'b1;
      end
    end
  end

  // ---- checks
  a_done_after_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_SCAN))
    else $error("result strobe without a finished scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(MAP_DEPTH))
    else $error("landmark count beyond map depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(created_new && map_full))
    else $error("created and full flagged together");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (done && created_new))
    else $error("map grew without a creation result");

endmodule

### tb/sv/landmark_association_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// landmark_association_checker
// Watches the reading, result and radius channels. It keeps its own landmark
// map, projects each accepted reading, predicts the association result and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module landmark_association_checker #(
  parameter int MAP_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [23:0] robot_x,
  input  logic signed [23:0] robot_y,
  input  logic [15:0]        robot_heading,
  input  logic [15:0]        meas_range,
  input  logic [15:0]        meas_bearing,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [22:0]        cfg_data,
  input  logic               done,
  input  logic [7:0]         landmark_index,
  input  logic               created_new,
  input  logic               map_full,
  input  logic signed [23:0] point_x,
  input  logic signed [23:0] point_y,
  output int                 errors,
  output int                 outstanding,
  output int                 n_matched,
  output int                 n_created,
  output int                 n_full
);

  typedef struct {
    logic [7:0]         idx;
    logic               created;
    logic               full;
    logic signed [23:0] px;
    logic signed [23:0] py;
  } assoc_t;

  localparam int ATAN_TAB [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                   41, 20, 10, 5, 3, 1};

  logic signed [23:0] lm_x [MAP_DEPTH];
  logic signed [23:0] lm_y [MAP_DEPTH];
  int                 lm_count;
  logic [22:0]        radius;
  assoc_t             pending_q [$];

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // CORDIC rotation of the gain-scaled range, folded to the right half plane
  function automatic void project(input logic [15:0] rng, input logic [15:0] ang,
                                  output longint ox, output longint oy);
    longint     x, y, xs, ys;
    int         z;
    logic [15:0] a;
    bit         flip;
    x = ((longint'(rng) << 4) * 39797 + 32768) >>> 16;
    y = 0;
    a = ang;
    flip = (a >= 16'd16384) && (a < 16'd49152);
    if (flip) a = a ^ 16'h8000;
    z = (a < 16'd32768) ? int'(a) : int'(a) - 65536;
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z -= ATAN_TAB[i];
      end else begin
        x = x + ys; y = y - xs; z += ATAN_TAB[i];
      end
    end
    ox = flip ? -x : x;
    oy = flip ? -y : y;
  endfunction

  function automatic assoc_t associate(input logic signed [23:0] rx,
                                       input logic signed [23:0] ry,
                                       input logic [15:0] ang, input logic [15:0] rng);
    assoc_t  r;
    longint  dx, dy, px, py, ex, ey;
    longint unsigned d2, best, thr2;
    int      best_j;
    project(rng, ang, dx, dy);
    px = clamp24(longint'(rx) + dx);
    py = clamp24(longint'(ry) + dy);
    best = 0;
    best_j = -1;
    for (int j = 0; j < lm_count; j++) begin
      ex = px - longint'(lm_x[j]);
      ey = py - longint'(lm_y[j]);
      d2 = ex * ex + ey * ey;
      if (best_j < 0 || d2 < best) begin
        best = d2; best_j = j;
      end
    end
    thr2 = longint'(radius) * longint'(radius);
    r.px = px[23:0];
    r.py = py[23:0];
    r.created = 1'b0;
    r.full = 1'b0;
    r.idx = '0;
    if (best_j >= 0 && best < thr2) begin
      r.idx = best_j[7:0];
    end else if (lm_count < MAP_DEPTH) begin
      lm_x[lm_count] = px[23:0];
      lm_y[lm_count] = py[23:0];
      r.idx = lm_count[7:0];
      r.created = 1'b1;
      lm_count++;
    end else begin
      r.full = 1'b1;
    end
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  assign outstanding = pending_q.size();

  always @(posedge clk) begin
    assoc_t e, w;
    if (rst) begin
      lm_count = 0;
      radius   = 23'd40960;
      pending_q.delete();
      errors = 0; n_matched = 0; n_created = 0; n_full = 0;
    end else begin
      if (done) begin
        if (pending_q.size() == 0) begin
          report("unexpected result", landmark_index, -1);
        end else begin
          w = pending_q.pop_front();
          if (landmark_index !== w.idx) report("landmark_index", landmark_index, w.idx);
          if (created_new !== w.created) report("created_new", created_new, w.created);
          if (map_full !== w.full) report("map_full", map_full, w.full);
          if (point_x !== w.px) report("point_x", point_x, w.px);
          if (point_y !== w.py) report("point_y", point_y, w.py);
        end
      end
      if (cfg_valid && cfg_ready) radius = cfg_data;
      if (start && !busy) begin
        e = associate(robot_x, robot_y, robot_heading + meas_bearing, meas_range);
        if (e.created) n_created++;
        else if (e.full) n_full++;
        else n_matched++;
        pending_q.insert(pending_q.size(), e);
      end
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives readings and radius writes into the association block, with a
// checker alongside that predicts every result; gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG = 20000;   // cycles without any transfer

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [23:0] robot_x = '0;
  logic signed [23:0] robot_y = '0;
  logic [15:0]        robot_heading = '0;
  logic [15:0]        meas_range = '0;
  logic [15:0]        meas_bearing = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [22:0]        cfg_data = '0;
  logic               done;
  logic [7:0]         landmark_index;
  logic               created_new;
  logic               map_full;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;

  int errors, outstanding, n_matched, n_created, n_full;
  int sent;          // readings transferred so far
  int idle_pct;      // sender idle chance in percent, drawn once per reading
  int quiet;         // watchdog count

  always #5 clk = ~clk;

  landmark_data_association_top dut (.*);

  landmark_association_checker chk (.*);

  // Watchdog: any reading, result or radius transfer restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // One reading; start stays up straight into the next item when no gap
  // is drawn, so it is never dropped and raised in the same step.
  task automatic send_reading(input logic signed [23:0] x, input logic signed [23:0] y,
                              input logic [15:0] hd, input logic [15:0] rg,
                              input logic [15:0] br);
    int gap;
    robot_x       <= x;
    robot_y       <= y;
    robot_heading <= hd;
    meas_range    <= rg;
    meas_bearing  <= br;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    idle_pct = (sent < 600) ? 30 : (sent < 1200) ? 86 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every result is in, then let the block settle.
  task automatic drain;
    @(posedge clk);
    start <= 1'b0;
    while (outstanding > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_radius(input logic [22:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a robot wandering a 100 m square seeing nearby landmarks, so
  // readings cluster and both matches and new entries occur; a tenth noise.
  task automatic random_readings(input int n);
    logic signed [23:0] x, y;
    logic [15:0]        rg;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        x  = 24'($urandom());
        y  = 24'($urandom());
        rg = 16'($urandom());
      end else begin
        x  = 24'($urandom_range(409600) - 204800);
        y  = 24'($urandom_range(409600) - 204800);
        rg = 16'($urandom_range(5120));
      end
      send_reading(x, y, 16'($urandom()), rg, 16'($urandom()));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty map first, then range and angle extremes, quadrant
    // folding boundaries and saturation of the projected point.
    send_reading(24'sd0, 24'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd0, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd16384, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd16383, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd32768, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd49151, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'd49152, 16'hFFFF, 16'd0);
    send_reading(24'sd0, 24'sd0, 16'hFFFF, 16'h1000, 16'd1);
    send_reading(24'sd0, 24'sd0, 16'h8000, 16'h1000, 16'h8000);
    send_reading(24'sh7FFFFF, 24'sh7FFFFF, 16'd0, 16'hFFFF, 16'd8192);
    send_reading(-24'sh800000, -24'sh800000, 16'd32768, 16'hFFFF, 16'd8192);
    send_reading(24'sh7FFFFF, -24'sh800000, 16'd0, 16'd0, 16'd0);
    send_reading(-24'sh800000, 24'sh7FFFFF, 16'hFFFF, 16'd1, 16'hFFFF);
    send_reading(24'sd100, 24'sd100, 16'd0, 16'd10, 16'd0);
    send_reading(24'sd40959, 24'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(24'sd40960, 24'sd0, 16'd0, 16'd0, 16'd0);
    send_reading(24'sh555555, 24'shAAAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_reading(24'shAAAAAA, 24'sh555555, 16'hAAAA, 16'h5555, 16'hAAAA);

    // Pause until all results are in before the first random stretch.
    write_radius(23'd40960);
    random_readings(660);
    write_radius(23'h7FFFFF);       // wide radius: most readings match the nearest entry
    random_readings(280);
    write_radius(23'($urandom_range(4096, 81920)));
    random_readings(420);
    write_radius(23'd0);            // nothing matches: fills, then map full
    random_readings(420);

    drain();
    $display("covered %0d readings: %0d matched, %0d new, %0d with map full",
             sent, n_matched, n_created, n_full);
    $display("radius written at reset value, maximum, random and zero");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
